@@ sv/svm_pkg.sv @@
// Shared types, constants and the control store of the voice mixer.
package svm_pkg;

    // Field widths
    localparam int REQ_W      = 2;
    localparam int INSTR_W    = 2;
    localparam int SADDR_W    = 15;
    localparam int SAMPLE_W   = 16;
    localparam int GAIN_W     = 16;
    localparam int ACTIVE_W   = 5;
    localparam int LEN_W      = 16;
    localparam int PROD_W     = SAMPLE_W + GAIN_W + 1;

    // Rounding of the sum of Q4.29 products down to Q1.15
    localparam int FRAC_W     = 14;
    localparam int ROUND_HALF = 8192;
    localparam int SAMPLE_MAX = 32767;
    localparam int SAMPLE_MIN = -32768;

    // Register port
    localparam int NUM_LEN_REGS = 4;
    localparam int PADDR_W      = 4;
    localparam int PDATA_W      = 32;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_START = 2'd1;
    localparam logic [REQ_W-1:0] REQ_TICK  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_NOP   = 2'd3;

    // Result kinds
    localparam logic RES_MIX    = 1'b0;
    localparam logic RES_REFUSE = 1'b1;

    typedef struct packed {
        logic [REQ_W-1:0]           req_type;
        logic [INSTR_W-1:0]         instrument;
        logic [SADDR_W-1:0]         sample_address;
        logic signed [SAMPLE_W-1:0] sample_value;
        logic [GAIN_W-1:0]          volume;
    } t_in_item;

    typedef struct packed {
        logic                       result_kind;
        logic signed [SAMPLE_W-1:0] mixed_sample;
        logic [ACTIVE_W-1:0]        active_voices;
    } t_out_item;

    typedef logic [NUM_LEN_REGS-1:0][LEN_W-1:0] t_len_regs;

    // Sequencer steps
    localparam int PC_W = 4;
    localparam logic [PC_W-1:0] STEP_FETCH    = 4'd0;
    localparam logic [PC_W-1:0] STEP_LOAD     = 4'd1;
    localparam logic [PC_W-1:0] STEP_START    = 4'd2;
    localparam logic [PC_W-1:0] STEP_SCAN     = 4'd3;
    localparam logic [PC_W-1:0] STEP_SCAN_END = 4'd4;
    localparam logic [PC_W-1:0] STEP_REFUSE   = 4'd5;
    localparam logic [PC_W-1:0] STEP_TICK     = 4'd6;
    localparam logic [PC_W-1:0] STEP_DRAIN1   = 4'd7;
    localparam logic [PC_W-1:0] STEP_DRAIN2   = 4'd8;
    localparam logic [PC_W-1:0] STEP_EMIT     = 4'd9;

    // Jump conditions
    localparam int COND_W = 3;
    localparam logic [COND_W-1:0] COND_NEVER    = 3'd0;
    localparam logic [COND_W-1:0] COND_ALWAYS   = 3'd1;
    localparam logic [COND_W-1:0] COND_DISPATCH = 3'd2;
    localparam logic [COND_W-1:0] COND_LEN_ZERO = 3'd3;
    localparam logic [COND_W-1:0] COND_NOT_LAST = 3'd4;
    localparam logic [COND_W-1:0] COND_SCAN_ON  = 3'd5;
    localparam logic [COND_W-1:0] COND_HIT      = 3'd6;

    typedef struct packed {
        logic              accept;
        logic              inc_v;
        logic              claim;
        logic              issue;
        logic              mem_wr;
        logic              emit_mix;
        logic              emit_refuse;
        logic [COND_W-1:0] cond;
        logic [PC_W-1:0]   target;
    } t_uword;

    typedef struct packed {
        logic len_zero;
        logic free;
        logic last;
        logic hit;
        logic out_busy;
    } t_flags;

    // Control store: one word per step
    function automatic t_uword ucode(input logic [PC_W-1:0] pc);
        t_uword uw;
        uw        = '0;
        uw.cond   = COND_NEVER;
        uw.target = STEP_FETCH;
        case (pc)
            STEP_FETCH: begin
                uw.accept = 1'b1;
                uw.cond   = COND_DISPATCH;
            end
            STEP_LOAD: begin
                uw.mem_wr = 1'b1;
                uw.cond   = COND_ALWAYS;
            end
            STEP_START: begin
                uw.cond   = COND_LEN_ZERO;
                uw.target = STEP_REFUSE;
            end
            STEP_SCAN: begin
                uw.claim  = 1'b1;
                uw.inc_v  = 1'b1;
                uw.cond   = COND_SCAN_ON;
                uw.target = STEP_SCAN;
            end
            STEP_SCAN_END: begin
                uw.cond   = COND_HIT;
                uw.target = STEP_FETCH;
            end
            STEP_REFUSE: begin
                uw.emit_refuse = 1'b1;
                uw.cond        = COND_ALWAYS;
            end
            STEP_TICK: begin
                uw.issue  = 1'b1;
                uw.inc_v  = 1'b1;
                uw.cond   = COND_NOT_LAST;
                uw.target = STEP_TICK;
            end
            STEP_DRAIN1: begin
                uw.cond = COND_NEVER;
            end
            STEP_DRAIN2: begin
                uw.cond = COND_NEVER;
            end
            STEP_EMIT: begin
                uw.emit_mix = 1'b1;
                uw.cond     = COND_ALWAYS;
            end
            default: begin
                uw.cond = COND_ALWAYS;
            end
        endcase
        return uw;
    endfunction

    // Entry step of each request's program
    function automatic logic [PC_W-1:0] dispatch_target(input logic [REQ_W-1:0] req);
        logic [PC_W-1:0] pc;
        case (req)
            REQ_LOAD:  pc = STEP_LOAD;
            REQ_START: pc = STEP_START;
            REQ_TICK:  pc = STEP_TICK;
            default:   pc = STEP_FETCH;
        endcase
        return pc;
    endfunction

endpackage

@@ sv/sample_voice_mixer.sv @@
// Top level of the sample-playback voice mixer: register port, sequencer, datapath, memory.
// Tick: the voice loop issues one sample read and multiply per cycle on the memory port, then the
//   pipeline drains and the result is emitted; the next item is taken only after the tick is done.
// Load: writes the sample when its address is in range. Start: its duration is set by the free-slot scan;
//   a result register held full by the consumer adds its stall cycles to a tick or a refusal.
// Reset (synchronous, active low) clears length registers, voice slot active bits, sequencer and
//   result register; sample memory keeps its contents and needs no clearing pass.
module sample_voice_mixer #(
    parameter int MAX_VOICES             = 16,
    parameter int NUM_INSTRUMENTS        = 4,
    parameter int SAMPLES_PER_INSTRUMENT = 32768
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  svm_pkg::t_in_item             i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output svm_pkg::t_out_item            o_out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [svm_pkg::PADDR_W-1:0]   paddr,
    input  logic [svm_pkg::PDATA_W-1:0]   pwdata,
    output logic [svm_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);
    import svm_pkg::*;

    localparam int MEM_DEPTH = NUM_INSTRUMENTS * SAMPLES_PER_INSTRUMENT;
    localparam int AW        = $clog2(MEM_DEPTH);

    t_len_regs              r_len;
    t_uword                 w_uw;
    t_flags                 w_flags;
    logic                   w_ram_we;
    logic [AW-1:0]          w_ram_addr;
    logic [SAMPLE_W-1:0]    w_ram_wdata;
    logic [SAMPLE_W-1:0]    w_ram_rdata;
    logic [PADDR_W-3:0]     w_reg_idx;

    // Length registers on the register port
    assign w_reg_idx = paddr[PADDR_W-1:2];
    assign pready    = 1'b1;
    assign prdata    = PDATA_W'(r_len[w_reg_idx]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
        end else if (psel && penable && pwrite && pready) begin
            r_len[w_reg_idx] <= pwdata[LEN_W-1:0];
        end
    end

    svm_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_in_data.req_type),
        .i_flags    (w_flags),
        .o_uw       (w_uw)
    );

    svm_dpath #(
        .MAX_VOICES             (MAX_VOICES),
        .NUM_INSTRUMENTS        (NUM_INSTRUMENTS),
        .SAMPLES_PER_INSTRUMENT (SAMPLES_PER_INSTRUMENT)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_uw        (w_uw),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .i_len       (r_len),
        .o_flags     (w_flags),
        .o_ram_we    (w_ram_we),
        .o_ram_addr  (w_ram_addr),
        .o_ram_wdata (w_ram_wdata),
        .i_ram_rdata (w_ram_rdata),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    svm_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MEM_DEPTH)
    ) u_sample_mem (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_addr  (w_ram_addr),
        .i_wdata (w_ram_wdata),
        .o_rdata (w_ram_rdata)
    );

    assign o_in_ready = w_uw.accept;

    // A refusal never carries a mix value
    a_refuse_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.result_kind == RES_REFUSE) |-> o_out_data.mixed_sample == '0)
        else $error("refusal result with nonzero sample");

    // A real request keeps the input closed on the next cycle
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in_data.req_type != REQ_NOP) |=> !o_in_ready)
        else $error("input reopened while an item is in progress");

    // Voice count never exceeds the slot pool
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (MAX_VOICES >= 32 || 32'(o_out_data.active_voices) <= MAX_VOICES))
        else $error("active voice count out of range");

    // Reset empties the result register
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

@@ sv/svm_ram.sv @@
// Generic single-port RAM with registered read data.
module svm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/svm_seq.sv @@
// Microcode sequencer: step counter, control store fetch and jump logic.
module svm_seq (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic [svm_pkg::REQ_W-1:0]        i_req_type,
    input  svm_pkg::t_flags                  i_flags,
    output svm_pkg::t_uword                  o_uw
);
    import svm_pkg::*;

    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    t_uword          w_uw;
    logic            w_take;
    logic            w_stall;

    // Fetch the control word and pick the next step
    always_comb begin
        w_uw    = ucode(r_pc);
        w_stall = (w_uw.emit_mix | w_uw.emit_refuse) & i_flags.out_busy;
        case (w_uw.cond)
            COND_NEVER:    w_take = 1'b0;
            COND_ALWAYS:   w_take = 1'b1;
            COND_DISPATCH: w_take = 1'b1;
            COND_LEN_ZERO: w_take = i_flags.len_zero;
            COND_NOT_LAST: w_take = !i_flags.last;
            COND_SCAN_ON:  w_take = !(i_flags.free | i_flags.last);
            COND_HIT:      w_take = i_flags.hit;
            default:       w_take = 1'b0;
        endcase
        n_pc = r_pc + 1'b1;
        if (w_uw.cond == COND_DISPATCH) begin
            n_pc = i_in_valid ? dispatch_target(i_req_type) : STEP_FETCH;
        end else if (w_take) begin
            n_pc = w_uw.target;
        end
        // hold while the result register is still full
        if (w_stall) begin
            n_pc = r_pc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= STEP_FETCH;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_uw = w_uw;

endmodule

@@ sv/svm_dpath.sv @@
// Datapath: voice slots, multiply-accumulate pipeline, rounding and result register.
module svm_dpath #(
    parameter int MAX_VOICES             = 16,
    parameter int NUM_INSTRUMENTS        = 4,
    parameter int SAMPLES_PER_INSTRUMENT = 32768
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  svm_pkg::t_uword       i_uw,
    input  logic                  i_in_valid,
    input  svm_pkg::t_in_item     i_in_data,
    input  svm_pkg::t_len_regs    i_len,
    output svm_pkg::t_flags       o_flags,
    output logic                  o_ram_we,
    output logic [$clog2(NUM_INSTRUMENTS*SAMPLES_PER_INSTRUMENT)-1:0] o_ram_addr,
    output logic [svm_pkg::SAMPLE_W-1:0] o_ram_wdata,
    input  logic [svm_pkg::SAMPLE_W-1:0] i_ram_rdata,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output svm_pkg::t_out_item    o_out_data
);
    import svm_pkg::*;

    localparam int AW    = $clog2(NUM_INSTRUMENTS * SAMPLES_PER_INSTRUMENT);
    localparam int VW    = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
    localparam int PW    = $clog2(SAMPLES_PER_INSTRUMENT);
    localparam int CPW   = PW + 1;
    localparam int LW    = $clog2(SAMPLES_PER_INSTRUMENT + 1);
    localparam int CW    = $clog2(MAX_VOICES + 1);
    localparam int ACC_W = PROD_W + CW;
    localparam logic [AW-1:0]        SPI_A   = AW'(SAMPLES_PER_INSTRUMENT);
    localparam logic signed [ACC_W:0] SAT_MAX = (ACC_W+1)'(SAMPLE_MAX);
    localparam logic signed [ACC_W:0] SAT_MIN = (ACC_W+1)'(SAMPLE_MIN);

    // Clamped length of an instrument, zero where the instrument does not exist
    function automatic logic [LW-1:0] len_of(input logic [INSTR_W-1:0] ins,
                                             input t_len_regs regs);
        logic [LEN_W-1:0] raw;
        logic [LW-1:0]    len;
        raw = regs[ins];
        len = '0;
        if (32'(ins) < NUM_INSTRUMENTS) begin
            if (32'(raw) > SAMPLES_PER_INSTRUMENT) begin
                len = LW'(SAMPLES_PER_INSTRUMENT);
            end else begin
                len = LW'(raw);
            end
        end
        return len;
    endfunction

    t_in_item                   r_item;
    logic [VW-1:0]              r_v;
    logic                       r_hit;
    logic [CW-1:0]              r_cnt;
    logic                       r_vact  [MAX_VOICES];
    logic [INSTR_W-1:0]         r_vinst [MAX_VOICES];
    logic [PW-1:0]              r_vpos  [MAX_VOICES];
    logic [GAIN_W-1:0]          r_vgain [MAX_VOICES];
    logic                       r_p1_vld;
    logic [GAIN_W-1:0]          r_p1_gain;
    logic                       r_p2_vld;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [ACC_W-1:0]    r_acc;
    logic                       r_out_valid;
    t_out_item                  r_out;
    logic                       n_out_valid;

    logic                       w_accept;
    logic                       w_last;
    logic                       w_cur_act;
    logic [INSTR_W-1:0]         w_cur_inst;
    logic [LW-1:0]              w_start_len;
    logic [LW-1:0]              w_voice_len;
    logic [CPW-1:0]             w_pos_ext;
    logic [CPW-1:0]             w_len_ext;
    logic [CPW-1:0]             w_pos_inc;
    logic                       w_play;
    logic                       w_done;
    logic                       w_claim;
    logic                       w_free_now;
    logic                       w_busy;
    logic                       w_load_out;
    logic signed [SAMPLE_W-1:0] w_smp;
    logic signed [GAIN_W:0]     w_gain;
    logic signed [PROD_W-1:0]   w_prod;
    logic signed [ACC_W:0]      w_rnd;
    logic signed [ACC_W:0]      w_q;
    logic signed [SAMPLE_W-1:0] w_mix;

    assign w_accept   = i_uw.accept & i_in_valid;
    assign w_last     = (r_v == VW'(MAX_VOICES - 1));
    assign w_cur_act  = r_vact[r_v];
    assign w_cur_inst = r_vinst[r_v];

    // Voice under the counter: does it play, and does it end this tick
    always_comb begin
        w_start_len = len_of(r_item.instrument, i_len);
        w_voice_len = len_of(w_cur_inst, i_len);
        w_pos_ext   = CPW'(r_vpos[r_v]);
        w_len_ext   = CPW'(w_voice_len);
        w_pos_inc   = w_pos_ext + 1'b1;
        w_play      = w_cur_act && (w_pos_ext < w_len_ext);
        w_done      = w_cur_act && (!w_play || (w_pos_inc >= w_len_ext));
        w_claim     = i_uw.claim && !w_cur_act;
        w_free_now  = i_uw.issue && w_done;
    end

    // Latch the item, walk the voice counter
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v   <= '0;
            r_hit <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (w_accept) begin
                r_v <= '0;
            end else if (i_uw.inc_v) begin
                r_v <= w_last ? '0 : r_v + 1'b1;
            end
            if (w_accept) begin
                r_hit <= 1'b0;
            end else if (w_claim) begin
                r_hit <= 1'b1;
            end
            if (w_claim) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_free_now) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Active bits of the voice slots
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_VOICES; i++) begin
                r_vact[i] <= 1'b0;
            end
        end else if (w_claim) begin
            r_vact[r_v] <= 1'b1;
        end else if (w_free_now) begin
            r_vact[r_v] <= 1'b0;
        end
    end

    // Instrument, position and gain of the voice slots
    always_ff @(posedge i_clk) begin
        if (w_claim) begin
            r_vinst[r_v] <= r_item.instrument;
            r_vpos[r_v]  <= '0;
            r_vgain[r_v] <= r_item.volume;
        end else if (w_free_now) begin
            r_vpos[r_v] <= '0;
        end else if (i_uw.issue && w_play) begin
            r_vpos[r_v] <= PW'(w_pos_inc);
        end
    end

    // Sample memory port: load writes, tick reads
    always_comb begin
        o_ram_we    = i_uw.mem_wr
                      && (32'(r_item.instrument) < NUM_INSTRUMENTS)
                      && (32'(r_item.sample_address) < SAMPLES_PER_INSTRUMENT);
        o_ram_wdata = r_item.sample_value;
        if (i_uw.mem_wr) begin
            o_ram_addr = AW'(r_item.instrument) * SPI_A + AW'(r_item.sample_address);
        end else begin
            o_ram_addr = AW'(w_cur_inst) * SPI_A + AW'(r_vpos[r_v]);
        end
    end

    // Multiply-accumulate pipeline: read, product, sum
    assign w_smp  = i_ram_rdata;
    assign w_gain = {1'b0, r_p1_gain};
    assign w_prod = w_smp * w_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld <= 1'b0;
            r_p2_vld <= 1'b0;
        end else begin
            r_p1_vld <= i_uw.issue && w_play;
            r_p2_vld <= r_p1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1_gain <= r_vgain[r_v];
        r_prod    <= w_prod;
        if (w_accept) begin
            r_acc <= '0;
        end else if (r_p2_vld) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    // Round to Q1.15 and saturate
    always_comb begin
        w_rnd = (ACC_W+1)'(r_acc) + (ACC_W+1)'(ROUND_HALF);
        w_q   = w_rnd >>> FRAC_W;
        if (w_q > SAT_MAX) begin
            w_mix = SAMPLE_W'(SAMPLE_MAX);
        end else if (w_q < SAT_MIN) begin
            w_mix = SAMPLE_W'(SAMPLE_MIN);
        end else begin
            w_mix = w_q[SAMPLE_W-1:0];
        end
    end

    // Result register: load when empty or being taken
    assign w_busy     = r_out_valid & !i_out_ready;
    assign w_load_out = (i_uw.emit_mix | i_uw.emit_refuse) & !w_busy;
    assign n_out_valid = w_load_out | w_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out.result_kind   <= i_uw.emit_refuse ? RES_REFUSE : RES_MIX;
            r_out.mixed_sample  <= i_uw.emit_refuse ? '0 : w_mix;
            r_out.active_voices <= ACTIVE_W'(r_cnt);
        end
    end

    always_comb begin
        o_flags.len_zero = (w_start_len == '0);
        o_flags.free     = !w_cur_act;
        o_flags.last     = w_last;
        o_flags.hit      = r_hit;
        o_flags.out_busy = w_busy;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ tb/tb.sv @@
// Self-checking bench for the voice mixer: random load/start/tick items checked by a predictor.
module tb;
    import svm_pkg::*;

    localparam int MAX_VOICES  = 16;
    localparam int NUM_INSTR   = 4;
    localparam int REGION      = 32768;
    localparam int SETTLE      = MAX_VOICES + 8;
    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 72;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_ready;
    t_in_item             i_in_data   = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    t_out_item            o_out_data;
    logic                 psel        = 1'b0;
    logic                 penable     = 1'b0;
    logic                 pwrite      = 1'b0;
    logic [PADDR_W-1:0]   paddr       = '0;
    logic [PDATA_W-1:0]   pwdata      = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    sample_voice_mixer #(
        .MAX_VOICES             (MAX_VOICES),
        .NUM_INSTRUMENTS        (NUM_INSTR),
        .SAMPLES_PER_INSTRUMENT (REGION)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Mirror of the mixer state
    logic                       v_on   [MAX_VOICES];
    logic [INSTR_W-1:0]         v_ins  [MAX_VOICES];
    int unsigned                v_pos  [MAX_VOICES];
    logic [GAIN_W-1:0]          v_gain [MAX_VOICES];
    logic [LEN_W-1:0]           len_reg [NUM_LEN_REGS];
    logic signed [SAMPLE_W-1:0] sample_store [int];

    t_in_item  items_to_drive [$];
    t_out_item results_due [$];

    int  items_queued  = 0;
    int  items_taken   = 0;
    int  cycle_count   = 0;
    int  err_count     = 0;
    int  mix_checked   = 0;
    int  refuse_checked = 0;
    int  reg_writes    = 0;
    bit  in_idle_on    = 1'b1;
    bit  out_idle_on   = 1'b1;
    int  in_gap        = 0;
    int  out_stall     = 0;

    function automatic int pick_gap(input bit on);
        int r;
        r = $urandom_range(99);
        if (!on || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    function automatic int unsigned play_length(input logic [INSTR_W-1:0] ins);
        int unsigned n;
        n = len_reg[ins];
        return (n > REGION) ? REGION : n;
    endfunction

    function automatic int mem_index(input logic [INSTR_W-1:0] ins, input int unsigned pos);
        return int'(ins) * REGION + int'(pos);
    endfunction

    function automatic logic [ACTIVE_W-1:0] voices_playing();
        logic [ACTIVE_W-1:0] n;
        n = '0;
        for (int v = 0; v < MAX_VOICES; v++)
            if (v_on[v])
                n = n + 1'b1;
        return n;
    endfunction

    function automatic t_in_item random_item();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[$bits(t_in_item)-1:0];
    endfunction

    // Advance the mirror by one item and queue the result it causes
    task automatic predict_mixer(input t_in_item it);
        t_out_item   res;
        int          slot;
        longint      acc;
        longint      s;
        longint      g;
        int unsigned n;
        int unsigned p;
        case (it.req_type)
            REQ_LOAD: begin
                sample_store[mem_index(it.instrument, it.sample_address)] = it.sample_value;
            end
            REQ_START: begin
                slot = -1;
                for (int v = 0; v < MAX_VOICES; v++)
                    if (!v_on[v] && slot < 0)
                        slot = v;
                if (slot < 0 || play_length(it.instrument) == 0) begin
                    res.result_kind   = RES_REFUSE;
                    res.mixed_sample  = '0;
                    res.active_voices = voices_playing();
                    results_due.insert(results_due.size(), res);
                end else begin
                    v_on[slot]   = 1'b1;
                    v_ins[slot]  = it.instrument;
                    v_pos[slot]  = 0;
                    v_gain[slot] = it.volume;
                end
            end
            REQ_TICK: begin
                acc = 0;
                for (int v = 0; v < MAX_VOICES; v++) begin
                    if (v_on[v]) begin
                        n = play_length(v_ins[v]);
                        p = v_pos[v];
                        if (p < n) begin
                            s = sample_store[mem_index(v_ins[v], p)];
                            g = v_gain[v];
                            acc += s * g;
                            p++;
                            v_pos[v] = p;
                        end
                        // drop voices that reached the end, shrunk lengths too
                        if (p >= n) begin
                            v_on[v]  = 1'b0;
                            v_pos[v] = 0;
                        end
                    end
                end
                acc = (acc + ROUND_HALF) >>> FRAC_W;
                if (acc > SAMPLE_MAX)
                    acc = SAMPLE_MAX;
                if (acc < SAMPLE_MIN)
                    acc = SAMPLE_MIN;
                res.result_kind   = RES_MIX;
                res.mixed_sample  = acc[SAMPLE_W-1:0];
                res.active_voices = voices_playing();
                results_due.insert(results_due.size(), res);
            end
            default: ;
        endcase
    endtask

    task automatic send(input t_in_item it);
        predict_mixer(it);
        items_to_drive.insert(items_to_drive.size(), it);
        items_queued++;
    endtask

    task automatic send_load(input logic [INSTR_W-1:0] ins, input int addr, input int value);
        t_in_item it;
        it                = random_item();
        it.req_type       = REQ_LOAD;
        it.instrument     = ins;
        it.sample_address = SADDR_W'(addr);
        it.sample_value   = SAMPLE_W'(value);
        send(it);
    endtask

    task automatic send_start(input logic [INSTR_W-1:0] ins, input logic [GAIN_W-1:0] vol);
        t_in_item it;
        it            = random_item();
        it.req_type   = REQ_START;
        it.instrument = ins;
        it.volume     = vol;
        send(it);
    endtask

    // Fill any sample a voice is about to read, then tick
    task automatic send_tick();
        t_in_item it;
        for (int v = 0; v < MAX_VOICES; v++)
            if (v_on[v] && v_pos[v] < play_length(v_ins[v])
                    && !sample_store.exists(mem_index(v_ins[v], v_pos[v])))
                send_load(v_ins[v], v_pos[v], $urandom);
        it          = random_item();
        it.req_type = REQ_TICK;
        send(it);
    endtask

    task automatic write_length(input int idx, input logic [LEN_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(4 * idx);
        pwdata  <= PDATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        len_reg[idx] = value;
        reg_writes++;
    endtask

    // Hold until every item is taken and every result has come back
    task automatic wait_idle();
        while (items_to_drive.size() != 0 || items_taken != items_queued
                || results_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic logic [LEN_W-1:0] pick_length();
        int r;
        r = $urandom_range(99);
        if (r < 15)
            return '0;
        if (r < 25) begin
            case ($urandom_range(2))
                0:       return 16'd32768;
                1:       return 16'd32767;
                default: return 16'hFFFF;
            endcase
        end
        return LEN_W'($urandom_range(24, 1));
    endfunction

    function automatic void report_bad(input string what, input t_out_item want,
                                       input t_out_item got);
        if (err_count < 10)
            $display({"cycle %0d %s: expected kind %0d sample %0d voices %0d,",
                      " got kind %0d sample %0d voices %0d"},
                     cycle_count, what, want.result_kind, want.mixed_sample,
                     want.active_voices, got.result_kind, got.mixed_sample, got.active_voices);
        err_count++;
    endfunction

    // Input driver: present queued items, with random gaps after each one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            in_gap     <= 0;
        end else if (!i_in_valid || o_in_ready) begin
            if (i_in_valid)
                items_taken <= items_taken + 1;
            if (in_gap > 0) begin
                in_gap     <= in_gap - 1;
                i_in_valid <= 1'b0;
            end else if (items_to_drive.size() != 0) begin
                i_in_data  <= items_to_drive.pop_front();
                i_in_valid <= 1'b1;
                in_gap     <= pick_gap(in_idle_on);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Result monitor: compare against the oldest prediction, stall at random
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            out_stall   <= 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (results_due.size() == 0) begin
                    report_bad("unexpected result", '0, o_out_data);
                end else begin
                    want = results_due.pop_front();
                    if (want.result_kind == RES_REFUSE)
                        refuse_checked++;
                    else
                        mix_checked++;
                    if (o_out_data.result_kind !== want.result_kind
                            || o_out_data.mixed_sample !== want.mixed_sample
                            || o_out_data.active_voices !== want.active_voices)
                        report_bad("result mismatch", want, o_out_data);
                end
            end
            if (out_stall > 0) begin
                i_out_ready <= 1'b0;
                out_stall   <= out_stall - 1;
            end else begin
                i_out_ready <= 1'b1;
                if ($urandom_range(99) < 20)
                    out_stall <= pick_gap(out_idle_on);
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        t_in_item it;
        int       goal;
        int       r;
        for (int v = 0; v < MAX_VOICES; v++) begin
            v_on[v]   = 1'b0;
            v_ins[v]  = '0;
            v_pos[v]  = 0;
            v_gain[v] = '0;
        end
        for (int i = 0; i < NUM_LEN_REGS; i++)
            len_reg[i] = '0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Zero lengths after reset: start refused, empty mix, no-op
        send_start(2'd0, 16'h4000);
        send_tick();
        it          = random_item();
        it.req_type = REQ_NOP;
        send(it);
        wait_idle();

        // Extreme lengths, extreme samples and gains, full slot pool
        write_length(0, 16'd2);
        write_length(1, 16'hFFFF);
        write_length(2, 16'd1);
        write_length(3, 16'd32768);
        send_load(2'd0, 0, 32767);
        send_load(2'd0, 1, -32768);
        send_load(2'd2, 0, -32768);
        send_load(2'd1, 32767, 16'h5555);
        send_load(2'd3, 0, 12345);
        send_load(2'd3, 1, -32768);
        send_start(2'd0, 16'hFFFF);
        send_start(2'd2, 16'hFFFF);
        send_start(2'd1, 16'h0000);
        for (int i = 0; i < MAX_VOICES - 3; i++)
            send_start(2'd3, 16'hFFFF);
        send_start(2'd3, 16'h1234);
        send_tick();
        send_tick();
        wait_idle();

        // Shrink lengths under playing voices
        write_length(3, 16'd1);
        write_length(1, 16'd0);
        send_tick();
        wait_idle();

        // Random phases, each with its own lengths and idle pattern
        for (int ph = 0; ph < PHASES; ph++) begin
            for (int i = 0; i < NUM_LEN_REGS; i++)
                write_length(i, pick_length());
            in_idle_on  = (ph % 3 != 1);
            out_idle_on = (ph % 3 != 2);
            goal = items_queued + PHASE_ITEMS;
            while (items_queued < goal) begin
                r  = $urandom_range(99);
                it = random_item();
                if (r < 22) begin
                    it.req_type = REQ_LOAD;
                    if ($urandom_range(1))
                        it.sample_address = SADDR_W'($urandom_range(31));
                    if ($urandom_range(7) == 0)
                        it.sample_value = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
                    send(it);
                end else if (r < 52) begin
                    it.req_type = REQ_START;
                    if ($urandom_range(7) == 0)
                        it.volume = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                    send(it);
                end else if (r < 95) begin
                    send_tick();
                end else begin
                    it.req_type = REQ_NOP;
                    send(it);
                end
            end
            wait_idle();
        end

        $display("drove %0d items over %0d length writes", items_queued, reg_writes);
        $display("checked %0d mixed samples and %0d refused starts", mix_checked,
                 refuse_checked);
        if (err_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ sim.f @@
sv/svm_pkg.sv
sv/svm_ram.sv
sv/svm_seq.sv
sv/svm_dpath.sv
sv/sample_voice_mixer.sv
tb/tb.sv
